[rtl/core/pkht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_pkg
// Shared types and constants for the pointer-keyed hash table: slot geometry,
// hash constants, command and status codes, beat structs and state encodings.
// ----------------------------------------------------------------------------
package pkht_pkg;

    // Table geometry (CAPACITY is a power of two)
    localparam int CAPACITY = 16384;
    localparam int HALF_CAP = CAPACITY / 2;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(HALF_CAP + 1);

    // Hash constants
    localparam logic [63:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
    localparam int          SHIFT_A    = 17;
    localparam int          SHIFT_B    = 29;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_ZERO_KEY = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    // Result beat
    typedef struct packed {
        logic        found;
        logic [31:0] result_value;
        status_t     status;
    } rsp_t;

    // Slot store write port
    typedef struct packed {
        logic              key_we;
        logic              val_we;
        logic [SLOT_W-1:0] addr;
        logic [63:0]       key;
        logic [31:0]       value;
    } mem_wr_t;

    // Slot store read port
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } mem_rd_t;

    // Hash unit phases
    typedef enum logic [2:0] {
        HP_IDLE,
        HP_LL,
        HP_HL,
        HP_LH,
        HP_OUT
    } hash_phase_t;

    // Top-level control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE
    } state_t;

endpackage

[rtl/core/pkht_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_hash
// Multi-cycle home-slot hash: xor-shift, 64-bit wrapping multiply built from
// three 32x32 partial products on one shared multiplier, xor-shift, mask.
// ----------------------------------------------------------------------------
module pkht_hash
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                key,
    output logic                       done,
    output logic [pkht_pkg::SLOT_W-1:0] slot
);

    pkht_pkg::hash_phase_t phase_reg;
    pkht_pkg::hash_phase_t phase_next;

    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [63:0] mixed;

    // Advance through the partial-product phases
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            pkht_pkg::HP_IDLE: if (start) phase_next = pkht_pkg::HP_LL;
            pkht_pkg::HP_LL:   phase_next = pkht_pkg::HP_HL;
            pkht_pkg::HP_HL:   phase_next = pkht_pkg::HP_LH;
            pkht_pkg::HP_LH:   phase_next = pkht_pkg::HP_OUT;
            pkht_pkg::HP_OUT:  phase_next = pkht_pkg::HP_IDLE;
            default:           phase_next = pkht_pkg::HP_IDLE;
        endcase
    end

    // Select multiplier operands and accumulate
    always_comb
    begin
        mul_a    = x_reg[31:0];
        mul_b    = pkht_pkg::GOLDEN_MUL[31:0];
        acc_next = acc_reg;
        done     = 1'b0;
        case (phase_reg)
            pkht_pkg::HP_LL:
            begin
                acc_next = product;
            end
            pkht_pkg::HP_HL:
            begin
                mul_a    = x_reg[63:32];
                acc_next = {acc_reg[63:32] + product[31:0], acc_reg[31:0]};
            end
            pkht_pkg::HP_LH:
            begin
                mul_b    = pkht_pkg::GOLDEN_MUL[63:32];
                acc_next = {acc_reg[63:32] + product[31:0], acc_reg[31:0]};
            end
            pkht_pkg::HP_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    assign product = {32'd0, mul_a} * {32'd0, mul_b};
    assign mixed   = acc_reg ^ (acc_reg >> pkht_pkg::SHIFT_B);
    assign slot    = mixed[pkht_pkg::SLOT_W-1:0];

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pkht_pkg::HP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Hold the mixed key and the product accumulator
    always_ff @(posedge clk)
    begin
        if (phase_reg == pkht_pkg::HP_IDLE && start)
        begin
            x_reg <= key ^ (key >> pkht_pkg::SHIFT_A);
        end
        acc_reg <= acc_next;
    end

endmodule

[rtl/core/pkht_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_store
// Slot store: key and handle arrays sharing one address space, one write
// port with separate key and handle enables, one registered read port.
// ----------------------------------------------------------------------------
module pkht_store
(
    input  logic                  clk,
    input  pkht_pkg::mem_wr_t     wr,
    input  pkht_pkg::mem_rd_t     rd,
    output logic [63:0]           rd_key,
    output logic [31:0]           rd_value
);

    logic [63:0] key_mem [pkht_pkg::CAPACITY];
    logic [31:0] val_mem [pkht_pkg::CAPACITY];

    // Write keys and handles
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.val_we)
        begin
            val_mem[wr.addr] <= wr.value;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_key   <= key_mem[rd.addr];
            rd_value <= val_mem[rd.addr];
        end
    end

endmodule

[rtl/core/pointer_keyed_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_keyed_hash_table
// Open-addressing hash table with linear probing, 64-bit key to 32-bit handle.
// ----------------------------------------------------------------------------
// A zero key is answered in the cycle after acceptance; any other key is
// hashed on one shared 32x32 multiplier, and probing then reads one slot per
// cycle from the key store, which has separate read and write ports.
// Requests are taken one at a time: start is accepted only while busy is low,
// and busy drops as the result shows. Reset: the key store is swept clear
// with busy high. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module pointer_keyed_hash_table
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pkht_pkg::req_t   request,
    output logic             done,
    output pkht_pkg::rsp_t   result
);

    pkht_pkg::state_t state_reg;
    pkht_pkg::state_t state_next;

    logic [pkht_pkg::SLOT_W-1:0]  clr_idx_reg;
    logic [pkht_pkg::SLOT_W-1:0]  clr_idx_next;
    pkht_pkg::req_t               req_reg;
    pkht_pkg::req_t               req_next;
    logic [pkht_pkg::SLOT_W-1:0]  pos_reg;
    logic [pkht_pkg::SLOT_W-1:0]  pos_next;
    logic [pkht_pkg::SLOT_W-1:0]  probes_reg;
    logic [pkht_pkg::SLOT_W-1:0]  probes_next;
    logic [pkht_pkg::COUNT_W-1:0] count_reg;
    logic [pkht_pkg::COUNT_W-1:0] count_next;
    logic                         done_reg;
    logic                         done_next;
    pkht_pkg::rsp_t               result_reg;
    pkht_pkg::rsp_t               result_next;

    logic                         accept;
    logic                         key_zero;
    logic                         hash_start;
    logic                         hash_done;
    logic [pkht_pkg::SLOT_W-1:0]  hash_slot;
    pkht_pkg::mem_wr_t            mem_wr;
    pkht_pkg::mem_rd_t            mem_rd;
    logic [63:0]                  rd_key;
    logic [31:0]                  rd_value;
    logic                         slot_hit;
    logic                         slot_empty;
    logic                         last_probe;
    logic                         table_full;
    logic                         probe_end;

    assign busy       = (state_reg != pkht_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign key_zero   = (request.key == 64'd0);
    assign hash_start = accept && !key_zero;

    // Probe decisions on the slot read last cycle
    assign slot_hit   = (rd_key == req_reg.key);
    assign slot_empty = (rd_key == 64'd0);
    assign last_probe = (probes_reg == '1);
    assign table_full = (count_reg >= pkht_pkg::COUNT_W'(pkht_pkg::HALF_CAP));
    assign probe_end  = slot_hit || slot_empty || last_probe;

    pkht_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (request.key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    pkht_store u_store
    (
        .clk      (clk),
        .wr       (mem_wr),
        .rd       (mem_rd),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pkht_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == '1) state_next = pkht_pkg::ST_IDLE;
            end
            pkht_pkg::ST_IDLE:
            begin
                if (hash_start) state_next = pkht_pkg::ST_HASH;
            end
            pkht_pkg::ST_HASH:
            begin
                if (hash_done) state_next = pkht_pkg::ST_PROBE;
            end
            pkht_pkg::ST_PROBE:
            begin
                if (probe_end) state_next = pkht_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pkht_pkg::ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        req_next     = req_reg;
        pos_next     = pos_reg;
        probes_next  = probes_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_wr       = '{key_we: 1'b0, val_we: 1'b0, addr: pos_reg,
                         key: req_reg.key, value: req_reg.value};
        mem_rd       = '{en: 1'b0, addr: pos_reg};
        case (state_reg)
            pkht_pkg::ST_CLEAR:
            begin
                // Sweep the key store to empty
                mem_wr.key_we = 1'b1;
                mem_wr.addr   = clr_idx_reg;
                mem_wr.key    = 64'd0;
                clr_idx_next  = clr_idx_reg + 1'b1;
            end
            pkht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = request;
                    if (key_zero)
                    begin
                        done_next   = 1'b1;
                        result_next = '{found: 1'b0, result_value: 32'd0,
                                        status: pkht_pkg::STATUS_ZERO_KEY};
                    end
                end
            end
            pkht_pkg::ST_HASH:
            begin
                // Issue the read of the home slot
                if (hash_done)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = hash_slot;
                    pos_next    = hash_slot;
                    probes_next = '0;
                end
            end
            pkht_pkg::ST_PROBE:
            begin
                result_next = '{found: 1'b0, result_value: 32'd0,
                                status: pkht_pkg::STATUS_OK};
                if (slot_hit)
                begin
                    done_next         = 1'b1;
                    result_next.found = 1'b1;
                    if (req_reg.cmd == pkht_pkg::CMD_LOOKUP)
                    begin
                        result_next.result_value = rd_value;
                    end
                    else
                    begin
                        mem_wr.val_we = 1'b1;
                    end
                end
                else if (slot_empty)
                begin
                    done_next = 1'b1;
                    if (req_reg.cmd == pkht_pkg::CMD_INSERT)
                    begin
                        if (table_full)
                        begin
                            result_next.status = pkht_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_wr.key_we = 1'b1;
                            mem_wr.val_we = 1'b1;
                            count_next    = count_reg + 1'b1;
                        end
                    end
                end
                else if (last_probe)
                begin
                    // Whole table walked with no empty slot
                    done_next = 1'b1;
                    if (req_reg.cmd == pkht_pkg::CMD_INSERT)
                    begin
                        result_next.status = pkht_pkg::STATUS_FULL;
                    end
                end
                else
                begin
                    // Advance to the next slot, wrapping
                    pos_next    = pos_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = pos_reg + 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pkht_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        pos_reg    <= pos_next;
        probes_reg <= probes_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Occupancy never passes half the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pkht_pkg::COUNT_W'(pkht_pkg::HALF_CAP))
        else $error("occupancy above half capacity");

    // A miss never returns a handle, a hit is never refused
    a_miss_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.result_value == 32'd0)
        else $error("handle returned on a miss");

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> result.status == pkht_pkg::STATUS_OK)
        else $error("hit reported with error status");

    // Store is never read and written in the same cycle outside the clear sweep
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pkht_pkg::ST_CLEAR |-> !(mem_rd.en && (mem_wr.key_we || mem_wr.val_we)))
        else $error("slot store read and write overlap");

    // A nonzero key enters hashing right after acceptance
    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_start |=> state_reg == pkht_pkg::ST_HASH && !done)
        else $error("accepted key did not start hashing");

    // Occupancy only grows by one on a completed insert
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1 && done)
        else $error("occupancy changed without an insert");

endmodule
